// File: rtl/bdq_pkg.sv
// Shared types and constants of the bounded deque with search.
package bdq_pkg;

	localparam int DEF_CAPACITY = 16;

	localparam int ACT_W  = 4;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 4;
	localparam int POS_W  = 4;
	localparam int OCC_W  = 5;
	localparam int STAT_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_BACK  = 4'd0,
		ACT_PUSH_FRONT = 4'd1,
		ACT_POP_BACK   = 4'd2,
		ACT_POP_FRONT  = 4'd3,
		ACT_DELETE     = 4'd4,
		ACT_REMOVE_AT  = 4'd5,
		ACT_GET        = 4'd6,
		ACT_FIND_FIRST = 4'd7,
		ACT_FIND_LAST  = 4'd8,
		ACT_COUNT      = 4'd9
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_PUSH_BACK,
		CMD_PUSH_FRONT,
		CMD_DROP
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t         cmd;
		logic [DATA_W-1:0] key;
	} cell_ctl_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

endpackage

// File: rtl/bdq_if.sv
// Request and response channel interfaces of the deque.
interface bdq_req_if;
	import bdq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] value;
	logic [IDX_W-1:0]         index;

	modport source (output valid, output action, output value, output index, input ready);
	modport sink (input valid, input action, input value, input index, output ready);
endinterface

interface bdq_rsp_if;
	import bdq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] data;
	logic [POS_W-1:0]         position;
	logic [OCC_W-1:0]         occupancy;
	logic [STAT_W-1:0]        status;

	modport source (output valid, output data, output position, output occupancy,
		output status, input ready);
	modport sink (input valid, input data, input position, input occupancy,
		input status, output ready);
endinterface

// File: rtl/bounded_deque_with_search.sv
// Top level of the bounded deque with search: controller, cell chain and response register.
// The response is registered at the end of the execute state that follows acceptance.
// Requests are taken only in the idle state, while the response register is free or read;
// the cell compare is registered, then the priority encode and the chain shift run in execute.
// Reset: asynchronous, active low; clears the fill count, the state and response valid.
// Entries are not cleared; no clearing pass is needed.
module bounded_deque_with_search import bdq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic     clk,
	input logic     arst_n,
	bdq_req_if.sink   req,
	bdq_rsp_if.source rsp
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int XW = (CW > IDX_W) ? CW : IDX_W;
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	state_t            state_q, state_d;
	logic [CW-1:0]     count_q, count_d;
	action_t           act_q;
	logic [DATA_W-1:0] key_q;
	logic [IDX_W-1:0]  idx_q;

	logic                 rsp_valid_q;
	logic [DATA_W-1:0]    rsp_data_q, data_d;
	logic [POS_W-1:0]     rsp_pos_q, pos_d;
	logic [OCC_W-1:0]     rsp_occ_q;
	logic [STAT_W-1:0]    rsp_stat_q;
	status_t              stat_d;

	cell_ctl_t         ctl;
	logic [CW-1:0]     pt;
	logic [DATA_W-1:0] ent [CAPACITY];
	logic [CAPACITY-1:0] hit;

	logic          accept, load_rsp;
	logic [IW-1:0] first_hit, last_hit;
	logic          any_hit;
	logic [XW-1:0] idx_ext;
	logic [CW-1:0] last_pos;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
	assign load_rsp = (state_q == S_EXEC);

	always_comb begin
		first_hit = '0;
		last_hit  = '0;
		any_hit   = 1'b0;
		for (int i = CAPACITY - 1; i >= 0; i--)
			if (hit[i])
				first_hit = IW'(i);
		for (int i = 0; i < CAPACITY; i++)
			if (hit[i])
				last_hit = IW'(i);
		any_hit = |hit;
	end

	assign idx_ext  = XW'(idx_q);
	assign last_pos = count_q - CW'(1);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ctl.cmd  = CMD_HOLD;
		ctl.key  = (state_q == S_IDLE) ? DATA_W'(req.value) : key_q;
		pt       = '0;
		data_d   = '0;
		pos_d    = '0;
		stat_d   = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (act_q >= ACT_POP_BACK && act_q <= ACT_FIND_LAST && count_q == '0) begin
					stat_d = ST_EMPTY;
				end else begin
					case (act_q)
						ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
							if (count_q >= CAP) begin
								stat_d = ST_FULL;
							end else begin
								ctl.cmd = (act_q == ACT_PUSH_BACK) ? CMD_PUSH_BACK
									: CMD_PUSH_FRONT;
								pt      = count_q;
								count_d = count_q + CW'(1);
							end
						end
						ACT_POP_BACK: begin
							data_d  = ent[last_pos[IW-1:0]];
							count_d = last_pos;
						end
						ACT_POP_FRONT: begin
							data_d  = ent[0];
							ctl.cmd = CMD_DROP;
							count_d = last_pos;
						end
						ACT_DELETE: begin
							if (!any_hit) begin
								stat_d = ST_MISS;
							end else begin
								data_d  = key_q;
								pos_d   = POS_W'(first_hit);
								ctl.cmd = CMD_DROP;
								pt      = CW'(first_hit);
								count_d = last_pos;
							end
						end
						ACT_REMOVE_AT, ACT_GET: begin
							if (idx_ext >= XW'(count_q)) begin
								stat_d = ST_MISS;
							end else begin
								data_d = ent[idx_ext[IW-1:0]];
								pos_d  = idx_q;
								if (act_q == ACT_REMOVE_AT) begin
									ctl.cmd = CMD_DROP;
									pt      = CW'(idx_ext);
									count_d = last_pos;
								end
							end
						end
						ACT_FIND_FIRST, ACT_FIND_LAST: begin
							if (!any_hit) begin
								stat_d = ST_MISS;
							end else begin
								data_d = key_q;
								pos_d  = (act_q == ACT_FIND_LAST) ? POS_W'(last_hit)
									: POS_W'(first_hit);
							end
						end
						default: ;
					endcase
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action_t'(req.action);
			key_q <= DATA_W'(req.value);
			idx_q <= req.index;
		end
		if (load_rsp) begin
			rsp_data_q <= data_d;
			rsp_pos_q  <= pos_d;
			rsp_occ_q  <= OCC_W'(count_d);
			rsp_stat_q <= stat_d;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left, right;
		if (i == 0) begin : g_first
			assign left = ent[i];
		end else begin : g_left
			assign left = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right = ent[i];
		end else begin : g_right
			assign right = ent[i+1];
		end
		bdq_cell #(
			.POS (i),
			.CW  (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.pt     (pt),
			.count  (count_q),
			.left   (left),
			.right  (right),
			.entry  (ent[i]),
			.match  (hit[i])
		);
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.data      = rsp_data_q;
	assign rsp.position  = rsp_pos_q;
	assign rsp.occupancy = rsp_occ_q;
	assign rsp.status    = rsp_stat_q;

endmodule

// File: rtl/bdq_cell.sv
// One storage cell of the deque chain: holds an entry, compares it, shifts with neighbours.
module bdq_cell import bdq_pkg::*; #(
	parameter int POS = 0,
	parameter int CW  = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctl_t         ctl,
	input  logic [CW-1:0]     pt,
	input  logic [CW-1:0]     count,
	input  logic [DATA_W-1:0] left,
	input  logic [DATA_W-1:0] right,
	output logic [DATA_W-1:0] entry,
	output logic              match
);

	localparam logic [CW-1:0] MY_POS = CW'(POS);

	logic [DATA_W-1:0] entry_q;
	logic [DATA_W-1:0] entry_d;
	logic              match_q;

	always_comb begin
		entry_d = entry_q;
		case (ctl.cmd)
			CMD_PUSH_BACK: begin
				if (MY_POS == pt)
					entry_d = ctl.key;
			end
			CMD_PUSH_FRONT: begin
				entry_d = (POS == 0) ? ctl.key : left;
			end
			CMD_DROP: begin
				if (MY_POS >= pt)
					entry_d = right;
			end
			default: entry_d = entry_q;
		endcase
	end

	always_ff @(posedge clk)
		entry_q <= entry_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			match_q <= 1'b0;
		else
			match_q <= (entry_q == ctl.key) && (MY_POS < count);
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// File: rtl/bdq_checker.sv
// Port-level assertions for the bounded deque, bound to the top level.
module bdq_checker import bdq_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic              clk,
	input logic              arst_n,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [DATA_W-1:0] rsp_data,
	input logic [POS_W-1:0]  rsp_position,
	input logic [OCC_W-1:0]  rsp_occupancy,
	input logic [STAT_W-1:0] rsp_status
);

	localparam logic [OCC_W-1:0] CAP_OCC = OCC_W'(CAPACITY);
	localparam bit NARROW = (CAPACITY < 32);

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (!NARROW || rsp_occupancy <= CAP_OCC))
		else $error("occupancy above capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_EMPTY) |->
			(rsp_data == '0 && rsp_position == '0 && rsp_occupancy == '0))
		else $error("empty response carries data or occupancy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_status == ST_FULL) |->
			(rsp_data == '0 && rsp_occupancy == CAP_OCC))
		else $error("refused push with store not full");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data) && $stable(rsp_status)))
		else $error("stalled response changed");

endmodule

bind bounded_deque_with_search bdq_checker #(.CAPACITY(CAPACITY)) u_bdq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_data      (rsp.data),
	.rsp_position  (rsp.position),
	.rsp_occupancy (rsp.occupancy),
	.rsp_status    (rsp.status)
);

// File: verif/tb_bounded_deque_with_search.sv
// Self-checking testbench of the bounded deque with search: directed table, then random requests.
module tb_bounded_deque_with_search;
	timeunit 1ns;
	timeprecision 1ps;
	import bdq_pkg::*;

	localparam logic [ACT_W-1:0]         ACT_NOP_FIRST = 4'hA;
	localparam logic [ACT_W-1:0]         ACT_NOP_LAST  = 4'hF;
	localparam logic signed [DATA_W-1:0] WORD_MIN      = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX      = 32'sh7fff_ffff;
	localparam int RAND_OPS     = 1000;
	localparam int HOLD_LEN     = 80;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         position;
		logic [OCC_W-1:0]         occupancy;
		status_t                  status;
	} deque_rsp_t;

	typedef struct {
		logic [ACT_W-1:0]         act;
		logic signed [DATA_W-1:0] val;
		logic [IDX_W-1:0]         idx;
		int                       reps;
		bit                       typed;
		deque_rsp_t               want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bdq_req_if req();
	bdq_rsp_if rsp();

	bounded_deque_with_search #(.CAPACITY(DEF_CAPACITY)) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	logic signed [DATA_W-1:0] shadow[$];
	deque_rsp_t               expected_rsp[$];
	deque_rsp_t               head_rsp;
	int                       mismatch_count = 0;
	int                       src_idle_pct = 10;
	int                       rcv_idle_pct = 52;
	int                       hold_asks = 0;
	int                       hold_seen = 0;
	int                       hold_left = 0;
	int                       stall_cycles = 0;

	// typed rows: empty store, full store, misses, count and no-op
	stim_row_t directed_rows[$] = '{
		'{ACT_COUNT,      32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_POP_BACK,   32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_POP_FRONT,  32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_DELETE,     32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_REMOVE_AT,  32'sd0,   4'd15, 1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_GET,        32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_FIND_FIRST, 32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_FIND_LAST,  32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_EMPTY}},
		'{ACT_NOP_LAST,   -32'sd1,  4'd15, 1, 1'b1, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_BACK,  WORD_MIN, 4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_FRONT, WORD_MAX, 4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_BACK,  -32'sd1,  4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_BACK,  32'sd5,   4'd0, 12, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_FRONT, 32'sd0,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_PUSH_BACK,  32'sd1,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd16, ST_FULL}},
		'{ACT_PUSH_FRONT, 32'sd1,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd16, ST_FULL}},
		'{ACT_GET,        32'sd0,   4'd15, 1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_FIND_FIRST, 32'sd5,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_FIND_LAST,  32'sd5,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_FIND_FIRST, 32'sd1234, 4'd0, 1, 1'b1, '{32'sd0, 4'd0, 5'd16, ST_MISS}},
		'{ACT_DELETE,     32'sd5,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_GET,        32'sd0,   4'd15, 1, 1'b1, '{32'sd0, 4'd0, 5'd15, ST_MISS}},
		'{ACT_REMOVE_AT,  32'sd0,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_POP_BACK,   32'sd0,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_POP_FRONT,  32'sd0,   4'd0,  1, 1'b0, '{32'sd0, 4'd0, 5'd0,  ST_OK}},
		'{ACT_COUNT,      32'sd7,   4'd3,  1, 1'b1, '{32'sd0, 4'd0, 5'd12, ST_OK}},
		'{ACT_NOP_FIRST,  32'sd0,   4'd0,  1, 1'b1, '{32'sd0, 4'd0, 5'd12, ST_OK}}
	};

	function automatic deque_rsp_t apply_request(input logic [ACT_W-1:0] act,
		input logic signed [DATA_W-1:0] val, input logic [IDX_W-1:0] idx);
		deque_rsp_t r;
		int         hit;
		r.data     = '0;
		r.position = '0;
		r.status   = ST_OK;
		hit        = -1;
		if (act >= ACT_POP_BACK && act <= ACT_FIND_LAST && shadow.size() == 0) begin
			r.status = ST_EMPTY;
		end else begin
			case (act)
				ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
					if (shadow.size() >= DEF_CAPACITY) r.status = ST_FULL;
					else if (act == ACT_PUSH_BACK) shadow.push_back(val);
					else shadow.push_front(val);
				end
				ACT_POP_BACK:  r.data = shadow.pop_back();
				ACT_POP_FRONT: r.data = shadow.pop_front();
				ACT_REMOVE_AT, ACT_GET: begin
					if (idx >= shadow.size()) begin
						r.status = ST_MISS;
					end else begin
						r.data     = shadow[idx];
						r.position = idx;
						if (act == ACT_REMOVE_AT) shadow.delete(idx);
					end
				end
				ACT_DELETE, ACT_FIND_FIRST, ACT_FIND_LAST: begin
					for (int i = 0; i < shadow.size(); i++)
						if (shadow[i] == val && (hit < 0 || act == ACT_FIND_LAST)) hit = i;
					if (hit < 0) begin
						r.status = ST_MISS;
					end else begin
						r.data     = shadow[hit];
						r.position = POS_W'(hit);
						if (act == ACT_DELETE) shadow.delete(hit);
					end
				end
				default: ;
			endcase
		end
		r.occupancy = OCC_W'(shadow.size());
		return r;
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value(input bit want_hit);
		logic signed [DATA_W-1:0] v;
		if (want_hit && shadow.size() > 0) return shadow[$urandom_range(shadow.size() - 1)];
		case ($urandom_range(3))
			0:       v = $urandom_range(7);
			1:       v = $urandom_range(1) ? WORD_MAX : ($urandom_range(1) ? WORD_MIN : -32'sd1);
			default: v = $urandom();
		endcase
		return v;
	endfunction

	task automatic issue_request(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
		input logic [IDX_W-1:0] idx, input bit typed, input deque_rsp_t want);
		deque_rsp_t predicted;
		while ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid  <= 1'b1;
		req.action <= act;
		req.value  <= val;
		req.index  <= idx;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predicted = apply_request(act, val, idx);
		expected_rsp.push_back(typed ? want : predicted);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// response side: random back-pressure, plus a long hold-off on request
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != hold_seen) begin
				hold_seen = hold_asks;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (expected_rsp.size() == 0) begin
				$error("response with no request outstanding");
				mismatch_count++;
			end else begin
				head_rsp = expected_rsp.pop_front();
				if (rsp.data !== head_rsp.data) begin
					$error("data: expected %0d, got %0d", head_rsp.data, rsp.data);
					mismatch_count++;
				end
				if (rsp.position !== head_rsp.position) begin
					$error("position: expected %0d, got %0d", head_rsp.position, rsp.position);
					mismatch_count++;
				end
				if (rsp.occupancy !== head_rsp.occupancy) begin
					$error("occupancy: expected %0d, got %0d", head_rsp.occupancy, rsp.occupancy);
					mismatch_count++;
				end
				if (rsp.status !== head_rsp.status) begin
					$error("status: expected %0d, got %0d", head_rsp.status, rsp.status);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		logic [ACT_W-1:0]         act;
		logic signed [DATA_W-1:0] val;
		logic [IDX_W-1:0]         idx;
		deque_rsp_t               none;
		int                       ops;
		int                       push_pct;
		int                       r;
		none   = '{32'sd0, 4'd0, 5'd0, ST_OK};
		ops    = 0;
		arst_n     <= 1'b0;
		req.valid  <= 1'b0;
		req.action <= '0;
		req.value  <= '0;
		req.index  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			repeat (directed_rows[i].reps)
				issue_request(directed_rows[i].act, directed_rows[i].val, directed_rows[i].idx,
					directed_rows[i].typed, directed_rows[i].want);

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0:       begin src_idle_pct = 10; rcv_idle_pct = 52; end
				1:       begin src_idle_pct = 52; rcv_idle_pct = 10; end
				default: begin src_idle_pct = 0;  rcv_idle_pct = 0;  hold_asks++; end
			endcase
			while (ops < (phase + 1) * RAND_OPS / 3) begin
				// alternate filling, draining and balanced stretches
				case ((ops / 48) % 3)
					0:       push_pct = 70;
					1:       push_pct = 20;
					default: push_pct = 45;
				endcase
				r = $urandom_range(99);
				if (r < 3) act = ACT_W'(ACT_NOP_FIRST + $urandom_range(5));
				else if (r < 3 + push_pct) act = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
				else act = ACT_W'($urandom_range(ACT_POP_BACK, ACT_COUNT));
				val = pick_value($urandom_range(9) < 7);
				if (shadow.size() > 0 && $urandom_range(3) != 0)
					idx = IDX_W'($urandom_range(shadow.size() - 1));
				else
					idx = IDX_W'($urandom_range(15));
				issue_request(act, val, idx, 1'b0, none);
				if (act < ACT_NOP_FIRST) ops++;
			end
		end

		req.valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/bdq_pkg.sv
rtl/bdq_if.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_search.sv
rtl/bdq_checker.sv
verif/tb_bounded_deque_with_search.sv
